### src/apu_pkg.sv
package apu_pkg;

	localparam int VALUE_WIDTH   = 32;
	localparam int FRACTION_BITS = 24;
	localparam int STEP_WIDTH    = 16;

	localparam int CFG_WIDTH   = FRACTION_BITS;
	localparam int CFG_INDEX_W = 3;
	localparam int MOM2_WIDTH  = VALUE_WIDTH - 1;
	localparam int CORR_WIDTH  = FRACTION_BITS + 1;
	localparam int CORR_STEPS  = STEP_WIDTH + 1;

	// bias corrected moments, root, final numerator and quotient
	localparam int HAT_WIDTH   = VALUE_WIDTH + FRACTION_BITS;
	localparam int ROOT_WIDTH  = (HAT_WIDTH + FRACTION_BITS) / 2;
	localparam int DENOM_WIDTH = ROOT_WIDTH + 1;
	localparam int PROD_WIDTH  = HAT_WIDTH + FRACTION_BITS;
	localparam int QUO_WIDTH   = VALUE_WIDTH + 1;
	localparam int SPLIT       = HAT_WIDTH / 2;

	localparam int LATENCY = 4 + HAT_WIDTH + ROOT_WIDTH + 2 + QUO_WIDTH + 1;

	localparam logic [CFG_WIDTH-1:0]  LEARNING_RATE_RESET = CFG_WIDTH'(16777);
	localparam logic [CFG_WIDTH-1:0]  FIRST_DECAY_RESET   = CFG_WIDTH'(15099494);
	localparam logic [CFG_WIDTH-1:0]  SECOND_DECAY_RESET  = CFG_WIDTH'(16760438);
	localparam logic [CFG_WIDTH-1:0]  STABILIZER_RESET    = CFG_WIDTH'(1);
	localparam logic [STEP_WIDTH-1:0] STEP_COUNT_RESET    = '0;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_LEARNING_RATE = 3'd0,
		CFG_FIRST_DECAY   = 3'd1,
		CFG_SECOND_DECAY  = 3'd2,
		CFG_STABILIZER    = 3'd3,
		CFG_STEP_COUNT    = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] gradient;
		logic signed [VALUE_WIDTH-1:0] first_moment_in;
		logic        [MOM2_WIDTH-1:0]  second_moment_in;
		logic signed [VALUE_WIDTH-1:0] param_in;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] param_out;
		logic signed [VALUE_WIDTH-1:0] first_moment_out;
		logic        [MOM2_WIDTH-1:0]  second_moment_out;
		logic                          saturated;
	} result_t;

	typedef struct packed {
		logic                  busy;
		logic [CORR_WIDTH-1:0] first;
		logic [CORR_WIDTH-1:0] second;
	} corr_t;

endpackage

### src/apu_div.sv
module apu_div #(
	parameter int NUM_W  = 56,
	parameter int DEN_W  = 25,
	parameter int QUO_W  = 56,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [NUM_W-1:0]  num,
	input  logic [DEN_W-1:0]  den,
	input  logic [SIDE_W-1:0] side_in,
	output logic [QUO_W-1:0]  quo,
	output logic              ovf,
	output logic [SIDE_W-1:0] side_out
);

	localparam int HEAD_W = NUM_W - QUO_W;

	logic [DEN_W-1:0]  rem_a  [QUO_W+1];
	logic [QUO_W-1:0]  low_a  [QUO_W+1];
	logic [QUO_W-1:0]  quo_a  [QUO_W+1];
	logic [DEN_W-1:0]  den_a  [QUO_W+1];
	logic              ovf_a  [QUO_W+1];
	logic [SIDE_W-1:0] side_a [QUO_W+1];

	logic [DEN_W-1:0] rem_init;
	logic             ovf_init;

	// numerator bits above the quotient range are reduced up front
	generate
		if (HEAD_W > 0) begin : g_head
			localparam int CMP_W = (HEAD_W > DEN_W) ? HEAD_W : DEN_W;
			logic [CMP_W-1:0] head_w;
			logic [CMP_W-1:0] den_w;
			always_comb begin
				head_w   = CMP_W'(num[NUM_W-1:QUO_W]);
				den_w    = CMP_W'(den);
				ovf_init = head_w >= den_w;
				rem_init = ovf_init ? '0 : head_w[DEN_W-1:0];
			end
		end else begin : g_nohead
			assign ovf_init = 1'b0;
			assign rem_init = '0;
		end
	endgenerate

	assign rem_a[0]  = rem_init;
	assign ovf_a[0]  = ovf_init;
	assign low_a[0]  = num[QUO_W-1:0];
	assign quo_a[0]  = '0;
	assign den_a[0]  = den;
	assign side_a[0] = side_in;

	genvar i;
	generate
		for (i = 0; i < QUO_W; i++) begin : g_stage
			logic [DEN_W:0] trial;
			logic           ge;
			assign trial = {rem_a[i], low_a[i][QUO_W-1]};
			assign ge    = trial >= {1'b0, den_a[i]};
			always_ff @(posedge clk) begin
				if (en) begin
					rem_a[i+1]  <= ge ? DEN_W'(trial - {1'b0, den_a[i]}) : trial[DEN_W-1:0];
					low_a[i+1]  <= low_a[i] << 1;
					quo_a[i+1]  <= {quo_a[i][QUO_W-2:0], ge};
					den_a[i+1]  <= den_a[i];
					ovf_a[i+1]  <= ovf_a[i];
					side_a[i+1] <= side_a[i];
				end
			end
		end
	endgenerate

	assign quo      = quo_a[QUO_W];
	assign ovf      = ovf_a[QUO_W];
	assign side_out = side_a[QUO_W];

endmodule

### src/apu_sqrt.sv
module apu_sqrt #(
	parameter int ROOT_W = 40,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                en,
	input  logic [2*ROOT_W-1:0] radicand,
	input  logic [SIDE_W-1:0]   side_in,
	output logic [ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]   side_out
);

	logic [ROOT_W+1:0]   rem_a  [ROOT_W+1];
	logic [ROOT_W-1:0]   root_a [ROOT_W+1];
	logic [2*ROOT_W-1:0] x_a    [ROOT_W+1];
	logic [SIDE_W-1:0]   side_a [ROOT_W+1];

	assign rem_a[0]  = '0;
	assign root_a[0] = '0;
	assign x_a[0]    = radicand;
	assign side_a[0] = side_in;

	// one root bit per stage, two radicand bits brought down each time
	genvar i;
	generate
		for (i = 0; i < ROOT_W; i++) begin : g_stage
			logic [ROOT_W+3:0] t;
			logic [ROOT_W+3:0] trial;
			logic              ge;
			assign t     = {rem_a[i], x_a[i][2*ROOT_W-1 -: 2]};
			assign trial = (ROOT_W+4)'({root_a[i], 2'b01});
			assign ge    = t >= trial;
			always_ff @(posedge clk) begin
				if (en) begin
					rem_a[i+1]  <= ge ? (ROOT_W+2)'(t - trial) : t[ROOT_W+1:0];
					root_a[i+1] <= {root_a[i][ROOT_W-2:0], ge};
					x_a[i+1]    <= x_a[i] << 2;
					side_a[i+1] <= side_a[i];
				end
			end
		end
	endgenerate

	assign root     = root_a[ROOT_W];
	assign side_out = side_a[ROOT_W];

endmodule

### src/apu_correction.sv
module apu_correction (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [apu_pkg::CFG_WIDTH-1:0]     first_decay,
	input  logic [apu_pkg::CFG_WIDTH-1:0]     second_decay,
	input  logic [apu_pkg::STEP_WIDTH-1:0]    step_count,
	output apu_pkg::corr_t                    corr
);

	localparam int F      = apu_pkg::FRACTION_BITS;
	localparam int ACC_W  = apu_pkg::CORR_WIDTH;
	localparam int EXP_W  = apu_pkg::STEP_WIDTH + 1;
	localparam int CNT_W  = $clog2(apu_pkg::CORR_STEPS);
	localparam logic [ACC_W-1:0] ONE_Q = ACC_W'(1) << F;
	localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(apu_pkg::CORR_STEPS - 1);

	logic             start_q, run_q;
	logic [CNT_W-1:0] cnt_q;
	logic [ACC_W-1:0] corr1_q, corr2_q;
	logic [ACC_W-1:0] acc1_q, acc2_q, acc1_nx, acc2_nx;
	logic [F-1:0]     base1_q, base2_q, base1_nx, base2_nx;
	logic [EXP_W-1:0] exp_q;

	// square and multiply, one exponent bit per cycle
	always_comb begin
		acc1_nx  = exp_q[0] ? ACC_W'(((ACC_W+F)'(acc1_q) * base1_q) >> F) : acc1_q;
		acc2_nx  = exp_q[0] ? ACC_W'(((ACC_W+F)'(acc2_q) * base2_q) >> F) : acc2_q;
		base1_nx = F'(((2*F)'(base1_q) * base1_q) >> F);
		base2_nx = F'(((2*F)'(base2_q) * base2_q) >> F);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b1;
			run_q   <= 1'b0;
			cnt_q   <= '0;
			corr1_q <= '0;
			corr2_q <= '0;
		end else begin
			start_q <= start;
			if (start_q) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LAST_STEP) begin
					run_q   <= 1'b0;
					corr1_q <= ONE_Q - acc1_nx;
					corr2_q <= ONE_Q - acc2_nx;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start_q) begin
			acc1_q  <= ONE_Q;
			acc2_q  <= ONE_Q;
			base1_q <= first_decay;
			base2_q <= second_decay;
			exp_q   <= EXP_W'(step_count) + 1'b1;
		end else if (run_q) begin
			acc1_q  <= acc1_nx;
			acc2_q  <= acc2_nx;
			base1_q <= base1_nx;
			base2_q <= base2_nx;
			exp_q   <= exp_q >> 1;
		end
	end

	assign corr.busy   = start_q | run_q;
	assign corr.first  = corr1_q;
	assign corr.second = corr2_q;

endmodule

### src/adam_parameter_update_core.sv
// throughput: one word per cycle; a stalled result freezes the whole pipeline in place
// the three pipelined long divisions and the root stage set the depth, one bit per stage
// reset clears valids and loads the register defaults, then item_ready stays low while
// the bias corrections are computed; a write of a decay or the step count repeats that
module adam_parameter_update_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_ready,
	input  apu_pkg::item_t                     item,
	output logic                               result_valid,
	input  logic                               result_ready,
	output apu_pkg::result_t                   result,
	input  logic                               cfg_write,
	input  logic [apu_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [apu_pkg::CFG_WIDTH-1:0]      cfg_data
);

	localparam int V      = apu_pkg::VALUE_WIDTH;
	localparam int F      = apu_pkg::FRACTION_BITS;
	localparam int M2     = apu_pkg::MOM2_WIDTH;
	localparam int CW     = apu_pkg::CORR_WIDTH;
	localparam int HW     = apu_pkg::HAT_WIDTH;
	localparam int RW     = apu_pkg::ROOT_WIDTH;
	localparam int DW     = apu_pkg::DENOM_WIDTH;
	localparam int PW     = apu_pkg::PROD_WIDTH;
	localparam int QW     = apu_pkg::QUO_WIDTH;
	localparam int SP     = apu_pkg::SPLIT;
	localparam int LAT    = apu_pkg::LATENCY;
	localparam int BM_W   = V + F + 1;
	localparam int GM_W   = V + F + 2;
	localparam int MS_W   = V + F + 3;
	localparam int GSQ_W  = 2 * V - F;
	localparam int BV_W   = F + M2;
	localparam int GV_W   = CW + GSQ_W;
	localparam int REST_W = 1 + V + M2 + V + 1;

	localparam logic [CW-1:0]   ONE_Q = CW'(1) << F;
	localparam logic [F-1:0]    HALF  = F'(1) << (F - 1);
	localparam logic [M2-1:0]   VMAX  = '1;
	localparam logic [V-1:0]    TOP   = V'(1) << (V - 1);

	// configuration registers
	logic [apu_pkg::CFG_WIDTH-1:0]  lr_q, b1_q, b2_q, eps_q;
	logic [apu_pkg::STEP_WIDTH-1:0] step_q;
	logic                           corr_start;
	apu_pkg::corr_t                 corr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q   <= apu_pkg::LEARNING_RATE_RESET;
			b1_q   <= apu_pkg::FIRST_DECAY_RESET;
			b2_q   <= apu_pkg::SECOND_DECAY_RESET;
			eps_q  <= apu_pkg::STABILIZER_RESET;
			step_q <= apu_pkg::STEP_COUNT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				apu_pkg::CFG_LEARNING_RATE: lr_q   <= cfg_data;
				apu_pkg::CFG_FIRST_DECAY:   b1_q   <= cfg_data;
				apu_pkg::CFG_SECOND_DECAY:  b2_q   <= cfg_data;
				apu_pkg::CFG_STABILIZER:    eps_q  <= cfg_data;
				apu_pkg::CFG_STEP_COUNT:    step_q <= cfg_data[apu_pkg::STEP_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign corr_start = cfg_write && (cfg_index == apu_pkg::CFG_FIRST_DECAY ||
		cfg_index == apu_pkg::CFG_SECOND_DECAY || cfg_index == apu_pkg::CFG_STEP_COUNT);

	apu_correction u_correction (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (corr_start),
		.first_decay  (b1_q),
		.second_decay (b2_q),
		.step_count   (step_q),
		.corr         (corr)
	);

	// flow control: every stage moves together
	logic           en, fire;
	logic [LAT-1:0] vld_q;

	assign en           = !vld_q[LAT-1] || result_ready;
	assign item_ready   = en && !corr.busy;
	assign fire         = item_valid && item_ready;
	assign result_valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], fire};
		end
	end

	// stage 1: moment products
	logic [CW-1:0]            omb1, omb2;
	logic [V-1:0]             gmag;
	logic signed [BM_W-1:0]   bm_s1;
	logic signed [GM_W-1:0]   gm_s1;
	logic [2*V-1:0]           gsq_raw_s1;
	logic [BV_W-1:0]          bv_s1;
	logic [V-1:0]             p_s1;

	assign omb1 = ONE_Q - CW'(b1_q);
	assign omb2 = ONE_Q - CW'(b2_q);
	assign gmag = item.gradient[V-1] ? V'(-item.gradient) : V'(item.gradient);

	always_ff @(posedge clk) begin
		if (en) begin
			bm_s1      <= $signed({1'b0, b1_q}) * item.first_moment_in;
			gm_s1      <= $signed({1'b0, omb1}) * item.gradient;
			gsq_raw_s1 <= gmag * gmag;
			bv_s1      <= b2_q * item.second_moment_in;
			p_s1       <= item.param_in;
		end
	end

	// stage 2: new first moment, rounded square of the gradient
	logic [MS_W-1:0]  msum;
	logic [2*V-1:0]   gsq_sum;
	logic [V-1:0]     m_s2;
	logic [GSQ_W-1:0] gsq_s2;
	logic [BV_W-1:0]  bv_s2;
	logic [V-1:0]     p_s2;

	assign msum    = MS_W'(bm_s1) + MS_W'(gm_s1) + MS_W'(HALF);
	assign gsq_sum = gsq_raw_s1 + (2*V)'(HALF);

	always_ff @(posedge clk) begin
		if (en) begin
			m_s2   <= msum[V+F-1:F];
			gsq_s2 <= gsq_sum[2*V-1:F];
			bv_s2  <= bv_s1;
			p_s2   <= p_s1;
		end
	end

	// stage 3: weighted square
	logic [GV_W-1:0] gv_s3;
	logic [BV_W-1:0] bv_s3;
	logic [V-1:0]    m_s3, p_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			gv_s3 <= omb2 * gsq_s2;
			bv_s3 <= bv_s2;
			m_s3  <= m_s2;
			p_s3  <= p_s2;
		end
	end

	// stage 4: new second moment with clipping, magnitude of the first
	logic [GV_W:0]   vsum;
	logic [GV_W-F:0] vshift;
	logic [M2-1:0]   v_s4;
	logic            vsat_s4, mneg_s4;
	logic [V-1:0]    mmag_s4, m_s4, p_s4;

	assign vsum   = (GV_W+1)'(bv_s3) + (GV_W+1)'(gv_s3) + (GV_W+1)'(HALF);
	assign vshift = vsum[GV_W:F];

	always_ff @(posedge clk) begin
		if (en) begin
			vsat_s4 <= vshift > (GV_W-F+1)'(VMAX);
			v_s4    <= (vshift > (GV_W-F+1)'(VMAX)) ? VMAX : vshift[M2-1:0];
			mneg_s4 <= m_s3[V-1];
			mmag_s4 <= m_s3[V-1] ? V'(-m_s3) : m_s3;
			m_s4    <= m_s3;
			p_s4    <= p_s3;
		end
	end

	// bias correction divides, both lanes side by side
	logic [CW-1:0]        c1, c2;
	logic [HW-1:0]        mhat, vhat;
	logic [V:0]           side1_out;
	logic [M2+V:0]        side2_out;

	assign c1 = (corr.first == '0) ? CW'(1) : corr.first;
	assign c2 = (corr.second == '0) ? CW'(1) : corr.second;

	apu_div #(.NUM_W(HW), .DEN_W(CW), .QUO_W(HW), .SIDE_W(V + 1)) u_div_first (
		.clk      (clk),
		.en       (en),
		.num      ({mmag_s4, F'(0)}),
		.den      (c1),
		.side_in  ({mneg_s4, p_s4}),
		.quo      (mhat),
		.ovf      (),
		.side_out (side1_out)
	);

	apu_div #(.NUM_W(HW), .DEN_W(CW), .QUO_W(HW), .SIDE_W(M2 + V + 1)) u_div_second (
		.clk      (clk),
		.en       (en),
		.num      (HW'({v_s4, F'(0)})),
		.den      (c2),
		.side_in  ({v_s4, m_s4, vsat_s4}),
		.quo      (vhat),
		.ovf      (),
		.side_out (side2_out)
	);

	// root of the corrected second moment
	logic [RW-1:0]      root;
	logic [HW-1:0]      mhat_r;
	logic [REST_W-1:0]  rest_r;

	apu_sqrt #(.ROOT_W(RW), .SIDE_W(HW + REST_W)) u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand ({vhat, F'(0)}),
		.side_in  ({mhat, side1_out, side2_out}),
		.root     (root),
		.side_out ({mhat_r, rest_r})
	);

	// stage 5: denominator, partial products of the numerator
	logic [DW-1:0]        denom_s5;
	logic                 mzero_s5;
	logic [SP+F-1:0]      pl_s5;
	logic [HW-SP+F-1:0]   ph_s5;
	logic [REST_W-1:0]    rest_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			denom_s5 <= DW'(root) + DW'(eps_q);
			mzero_s5 <= mhat_r == '0;
			pl_s5    <= mhat_r[SP-1:0] * lr_q;
			ph_s5    <= mhat_r[HW-1:SP] * lr_q;
			rest_s5  <= rest_r;
		end
	end

	// stage 6: full numerator
	logic [PW-1:0]     num_s6;
	logic [DW-1:0]     denom_s6;
	logic              mzero_s6;
	logic [REST_W-1:0] rest_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s6   <= (PW'(ph_s5) << SP) + PW'(pl_s5);
			denom_s6 <= denom_s5;
			mzero_s6 <= mzero_s5;
			rest_s6  <= rest_s5;
		end
	end

	// update step, quotient clipped: anything past the value range saturates anyway
	logic [QW-1:0]     q;
	logic              q_ovf;
	logic              mzero_d;
	logic [REST_W-1:0] rest_d;

	apu_div #(.NUM_W(PW), .DEN_W(DW), .QUO_W(QW), .SIDE_W(REST_W + 1)) u_div_update (
		.clk      (clk),
		.en       (en),
		.num      (num_s6),
		.den      (denom_s6),
		.side_in  ({mzero_s6, rest_s6}),
		.quo      (q),
		.ovf      (q_ovf),
		.side_out ({mzero_d, rest_d})
	);

	// final stage: apply the step in offset binary and clip
	logic          f_mneg, f_vsat;
	logic [V-1:0]  f_p, f_m;
	logic [M2-1:0] f_v;
	logic          big;
	logic [QW-1:0] qv;
	logic [V-1:0]  pu, pnew;
	logic          psat;

	assign {f_mneg, f_p, f_v, f_m, f_vsat} = rest_d;

	always_comb begin
		big = q_ovf && !mzero_d;
		qv  = mzero_d ? '0 : q;
		pu  = f_p ^ TOP;
		if (!f_mneg) begin
			psat = big || (qv > {1'b0, pu});
			pnew = psat ? '0 : pu - qv[V-1:0];
		end else begin
			psat = big || (qv > {1'b0, ~pu});
			pnew = psat ? '1 : pu + qv[V-1:0];
		end
	end

	apu_pkg::result_t result_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			result_s7.param_out         <= pnew ^ TOP;
			result_s7.first_moment_out  <= f_m;
			result_s7.second_moment_out <= f_v;
			result_s7.saturated         <= psat | f_vsat;
		end
	end

	assign result = result_s7;

endmodule

### src/apu_checker.sv
module apu_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               item_valid,
	input logic                               item_ready,
	input logic                               result_valid,
	input logic                               result_ready,
	input apu_pkg::result_t                   result,
	input logic                               cfg_write,
	input logic [apu_pkg::CFG_INDEX_W-1:0]    cfg_index
);

	localparam int CNT_W = $clog2(apu_pkg::LATENCY + 2);

	logic [CNT_W-1:0] cnt_q;
	logic             in_acc, out_acc;

	assign in_acc  = item_valid && item_ready;
	assign out_acc = result_valid && result_ready;

	// words inside the block
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);
		end
	end

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> cnt_q != '0)
		else $error("result word with no item word inside");

	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(apu_pkg::LATENCY))
		else $error("more words inside than pipeline stages");

	a_step_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_write && cfg_index == apu_pkg::CFG_STEP_COUNT |=> !item_ready)
		else $error("item taken while corrections recompute");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("stalled result word changed");

endmodule

bind adam_parameter_update_core apu_checker u_apu_checker (.*);

### dv/tb_adam_parameter_update_core.sv
module tb_adam_parameter_update_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] ONE_Q  = 64'd1 << apu_pkg::FRACTION_BITS;
	localparam logic [63:0] HALF_Q = ONE_Q >> 1;
	localparam logic [63:0] V_MASK = (64'd1 << apu_pkg::VALUE_WIDTH) - 1;
	localparam logic [63:0] V_MAX  = (64'd1 << (apu_pkg::VALUE_WIDTH - 1)) - 1;
	localparam logic [63:0] V_TOP  = 64'd1 << (apu_pkg::VALUE_WIDTH - 1);

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	apu_pkg::item_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	apu_pkg::result_t result;
	logic cfg_write = 1'b0;
	logic [apu_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [apu_pkg::CFG_WIDTH-1:0] cfg_data = '0;

	adam_parameter_update_core DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers and bias corrections
	logic [63:0] lr_q, b1_q, b2_q, eps_q, step_q;
	logic [63:0] corr1_q, corr2_q;

	apu_pkg::item_t pending_items[$];
	apu_pkg::result_t expected_updates[$];
	int mismatches = 0;
	int results_seen = 0;
	bit no_idle = 1'b0;

	function automatic logic [63:0] decay_power(logic [63:0] base, logic [63:0] e);
		logic [63:0] acc;
		acc = ONE_Q;
		for (int k = 0; k < apu_pkg::STEP_WIDTH + 1; k++) begin
			if (e[0])
				acc = (acc * base) >> apu_pkg::FRACTION_BITS;
			base = (base * base) >> apu_pkg::FRACTION_BITS;
			e = e >> 1;
		end
		return acc;
	endfunction

	function automatic void refresh_corrections();
		logic [63:0] t;
		t = step_q + 1;
		corr1_q = (ONE_Q - decay_power(b1_q, t)) & ((64'd1 << apu_pkg::CORR_WIDTH) - 1);
		corr2_q = (ONE_Q - decay_power(b2_q, t)) & ((64'd1 << apu_pkg::CORR_WIDTH) - 1);
	endfunction

	function automatic void apply_register(apu_pkg::cfg_index_t idx, logic [63:0] value);
		case (idx)
			apu_pkg::CFG_LEARNING_RATE: lr_q = value & 64'hFF_FFFF;
			apu_pkg::CFG_FIRST_DECAY: begin
				b1_q = value & 64'hFF_FFFF;
				refresh_corrections();
			end
			apu_pkg::CFG_SECOND_DECAY: begin
				b2_q = value & 64'hFF_FFFF;
				refresh_corrections();
			end
			apu_pkg::CFG_STABILIZER: eps_q = value & 64'hFF_FFFF;
			apu_pkg::CFG_STEP_COUNT: begin
				step_q = value & 64'hFFFF;
				refresh_corrections();
			end
			default: ;
		endcase
	endfunction

	function automatic logic [63:0] wide_root(logic [127:0] x);
		logic [127:0] rem, root, trial;
		rem = '0;
		root = '0;
		for (int k = 63; k >= 0; k--) begin
			rem = (rem << 2) | ((x >> (2 * k)) & 128'd3);
			trial = (root << 2) | 128'd1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 128'd1;
			end else begin
				root = root << 1;
			end
		end
		return root[63:0];
	endfunction

	function automatic apu_pkg::result_t adam_update(apu_pkg::item_t w);
		logic [63:0] g, m, v, p, acc, m_new, v_new, gmag, gsq, c1, c2, mmag, mhat, vhat;
		logic [63:0] denom, q, pu, pnew;
		logic signed [63:0] rounded;
		logic [127:0] num, quo;
		logic sat, mneg;
		apu_pkg::result_t r;
		sat = 1'b0;
		g = {{32{w.gradient[31]}}, w.gradient};
		m = {{32{w.first_moment_in[31]}}, w.first_moment_in};
		v = {33'd0, w.second_moment_in};
		p = {32'd0, w.param_in};

		acc = b1_q * m + (ONE_Q - b1_q) * g;
		rounded = acc + HALF_Q;
		m_new = rounded >>> apu_pkg::FRACTION_BITS;

		gmag = g[63] ? -g : g;
		gsq = (gmag * gmag + HALF_Q) >> apu_pkg::FRACTION_BITS;
		acc = b2_q * v + (ONE_Q - b2_q) * gsq;
		v_new = (acc + HALF_Q) >> apu_pkg::FRACTION_BITS;
		if (v_new > V_MAX) begin
			v_new = V_MAX;
			sat = 1'b1;
		end

		c1 = (corr1_q != 0) ? corr1_q : 64'd1;
		c2 = (corr2_q != 0) ? corr2_q : 64'd1;
		mneg = m_new[63];
		mmag = mneg ? -m_new : m_new;
		mhat = (mmag << apu_pkg::FRACTION_BITS) / c1;
		vhat = (v_new << apu_pkg::FRACTION_BITS) / c2;
		denom = wide_root({64'd0, vhat} << apu_pkg::FRACTION_BITS) + eps_q;

		if (mhat == 0) begin
			q = 0;
		end else if (denom == 0) begin
			// no denominator at all: unbounded step
			q = '1;
			sat = 1'b1;
		end else begin
			num = {64'd0, mhat} * {64'd0, lr_q};
			quo = num / {64'd0, denom};
			q = (quo[127:64] != 0) ? '1 : quo[63:0];
		end

		pu = p ^ V_TOP;
		if (!mneg) begin
			if (q > pu) begin
				pnew = 0;
				sat = 1'b1;
			end else begin
				pnew = pu - q;
			end
		end else begin
			if (q > V_MASK - pu) begin
				pnew = V_MASK;
				sat = 1'b1;
			end else begin
				pnew = pu + q;
			end
		end

		r.param_out = pnew[31:0] ^ V_TOP[31:0];
		r.first_moment_out = m_new[31:0];
		r.second_moment_out = v_new[30:0];
		r.saturated = sat;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 6))
			0, 1: return $urandom;
			2, 3: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
			4: return 32'($urandom_range(0, 32'h0000_1000)) - 32'h0000_0800;
			5: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: return 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
		endcase
	endfunction

	function automatic apu_pkg::item_t random_word();
		apu_pkg::item_t w;
		w.gradient = pick_value();
		w.first_moment_in = pick_value();
		w.second_moment_in = $urandom_range(0, 2) ? 31'($urandom_range(0, 32'h0800_0000))
			: 31'($urandom);
		w.param_in = pick_value();
		return w;
	endfunction

	function automatic void queue_word(logic [31:0] g, logic [31:0] m, logic [30:0] v,
			logic [31:0] p);
		apu_pkg::item_t w;
		w.gradient = g;
		w.first_moment_in = m;
		w.second_moment_in = v;
		w.param_in = p;
		pending_items.push_back(w);
	endfunction

	// driver
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (item_valid && item_ready)
				expected_updates.push_back(adam_update(item));
			if (!item_valid || item_ready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (pending_items.size() != 0) begin
					item <= pending_items.pop_front();
					item_valid <= 1'b1;
					send_gap <= no_idle ? 0 : pick_gap();
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	int recv_gap = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	always @(posedge clk or negedge arst_n) begin
		apu_pkg::result_t exp_word;
		if (!arst_n) begin
			result_ready <= 1'b0;
			recv_gap <= 0;
			hold_left <= 0;
		end else begin
			if (result_valid && result_ready) begin
				results_seen <= results_seen + 1;
				if (expected_updates.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word %h", result);
				end else begin
					exp_word = expected_updates.pop_front();
					if (result !== exp_word) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: param %h/%h m %h/%h v %h/%h sat %b/%b (exp/act)",
								exp_word.param_out, result.param_out,
								exp_word.first_moment_out, result.first_moment_out,
								exp_word.second_moment_out, result.second_moment_out,
								exp_word.saturated, result.saturated);
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (!hold_done && results_seen == 60) begin
				// long hold-off so the pipeline fills and item_ready drops
				hold_done <= 1'b1;
				hold_left <= 400;
				result_ready <= 1'b0;
			end else if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				recv_gap <= no_idle ? 0 : pick_gap();
			end
		end
	end

	task automatic write_register(apu_pkg::cfg_index_t idx,
			logic [apu_pkg::CFG_WIDTH-1:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		apply_register(idx, {40'd0, value});
	endtask

	task automatic finish_writes();
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic drain();
		while (pending_items.size() != 0 || item_valid || expected_updates.size() != 0)
			@(posedge clk);
		repeat (apu_pkg::LATENCY + 20) @(posedge clk);
	endtask

	task automatic add_random(int count);
		for (int i = 0; i < count; i++)
			pending_items.push_back(random_word());
	endtask

	initial begin
		lr_q = apu_pkg::LEARNING_RATE_RESET;
		b1_q = apu_pkg::FIRST_DECAY_RESET;
		b2_q = apu_pkg::SECOND_DECAY_RESET;
		eps_q = apu_pkg::STABILIZER_RESET;
		step_q = apu_pkg::STEP_COUNT_RESET;
		refresh_corrections();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: field extremes and saturation corners
		queue_word(32'h0, 32'h0, 31'h0, 32'h0);
		queue_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF);
		queue_word(32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000);
		queue_word(32'h7FFF_FFFF, 32'h0, 31'h0, 32'h8000_0000);
		queue_word(32'h8000_0000, 32'h0, 31'h0, 32'h7FFF_FFFF);
		queue_word(32'h0100_0000, 32'h0080_0000, 31'h0100_0000, 32'h0100_0000);
		queue_word(32'hFF00_0000, 32'hFF80_0000, 31'h0000_0001, 32'hFFFF_FFFF);
		queue_word(32'h0, 32'h8000_0000, 31'h0, 32'h7FFF_FFFF);
		queue_word(32'h0, 32'h7FFF_FFFF, 31'h0, 32'h8000_0000);
		queue_word(32'hFFFF_FFFF, 32'h0000_0001, 31'h5555_5555, 32'hAAAA_AAAA);
		queue_word(32'h5555_5555, 32'hAAAA_AAAA, 31'h2AAA_AAAA, 32'h5555_5555);
		add_random(150);
		drain();

		// no decay, no stabilizer, largest step size: zero-root corner
		write_register(apu_pkg::CFG_LEARNING_RATE, 24'hFF_FFFF);
		write_register(apu_pkg::CFG_FIRST_DECAY, 24'h0);
		write_register(apu_pkg::CFG_SECOND_DECAY, 24'h0);
		write_register(apu_pkg::CFG_STABILIZER, 24'h0);
		write_register(apu_pkg::CFG_STEP_COUNT, 16'h0);
		finish_writes();
		queue_word(32'h0000_0001, 32'h0, 31'h0, 32'h0);
		queue_word(32'hFFFF_FFFF, 32'h0, 31'h0, 32'h0);
		queue_word(32'h0, 32'h1234_5678, 31'h0, 32'h0);
		queue_word(32'h0000_0001, 32'h0, 31'h0, 32'h7FFF_FFFF);
		queue_word(32'hFFFF_FFFF, 32'h0, 31'h0, 32'h8000_0000);
		add_random(60);
		drain();

		// zero step size, decays, stabilizer and step count at their maximum
		no_idle = 1'b1;
		write_register(apu_pkg::CFG_LEARNING_RATE, 24'h0);
		write_register(apu_pkg::CFG_FIRST_DECAY, 24'hFF_FFFF);
		write_register(apu_pkg::CFG_SECOND_DECAY, 24'hFF_FFFF);
		write_register(apu_pkg::CFG_STABILIZER, 24'hFF_FFFF);
		write_register(apu_pkg::CFG_STEP_COUNT, 16'hFFFF);
		finish_writes();
		add_random(60);
		drain();
		no_idle = 1'b0;

		// typical training settings
		write_register(apu_pkg::CFG_LEARNING_RATE, 24'($urandom_range(1, 24'h01_0000)));
		write_register(apu_pkg::CFG_FIRST_DECAY, 24'd15099494);
		write_register(apu_pkg::CFG_SECOND_DECAY, 24'd16760438);
		write_register(apu_pkg::CFG_STABILIZER, 24'd1);
		write_register(apu_pkg::CFG_STEP_COUNT, 16'($urandom_range(0, 20)));
		finish_writes();
		add_random(60);
		drain();

		// random settings, the stabilizer limited to 0..255
		for (int ph = 0; ph < 2; ph++) begin
			write_register(apu_pkg::CFG_LEARNING_RATE, 24'($urandom));
			write_register(apu_pkg::CFG_FIRST_DECAY, 24'($urandom));
			write_register(apu_pkg::CFG_SECOND_DECAY, 24'($urandom));
			write_register(apu_pkg::CFG_STABILIZER, 24'($urandom_range(0, 255)));
			write_register(apu_pkg::CFG_STEP_COUNT, 16'($urandom));
			finish_writes();
			add_random(40);
			drain();
		end

		if (mismatches == 0 && expected_updates.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#5ms;
		$display("Some tests failed");
		$finish;
	end

endmodule
